// ===== design/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg: shared definitions for the calibrated sensor linearizer
// Payload types, sequencer states, status codes, the linearisation table and
// helper functions used by the divider, the top level and the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

    // Fixed-point format of the temperature output and table size.
    localparam int FRAC_BITS    = 5;
    localparam int TABLE_POINTS = 13;
    localparam int TAB_IDX_W    = $clog2(TABLE_POINTS);

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 16;
    localparam int TEMP_W   = 12;
    localparam int STATUS_W = 2;
    localparam int VAL_W    = 14;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int GAIN_SHIFT = 12;

    // Shared divider geometry: wide enough for the calibration quotient.
    localparam int DIV_NUM_W = 22;
    localparam int DIV_DEN_W = SAMPLE_W;

    // Calibration constants.
    localparam logic [GAIN_W-1:0]    UNITY_GAIN    = 16'd4096;
    localparam logic [DIV_NUM_W-1:0] CAL_NUMERATOR = 22'd2097152;
    localparam logic [GAIN_W-1:0]    GAIN_MAX      = 16'hFFFF;

    // Temperature of table point i is BASE_DEG + STEP_DEG * i degrees.
    localparam int BASE_DEG     = -20;
    localparam int STEP_DEG     = 5;
    localparam int INTERP_SCALE = STEP_DEG << FRAC_BITS;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BELOW = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ABOVE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO  = 2'd3;

    // Strictly increasing converter codes of the thermistor curve.
    localparam logic [SAMPLE_W-1:0] LIN_TAB [TABLE_POINTS] = '{
        10'd75,  10'd100, 10'd131, 10'd169, 10'd214, 10'd265, 10'd322,
        10'd384, 10'd447, 10'd512, 10'd574, 10'd633, 10'd687
    };

    // Input and result requests.
    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] adc_sample;
    } csl_in_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [GAIN_W-1:0]        gain_factor;
        logic [STATUS_W-1:0]      status;
    } csl_out_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RANGE,
        ST_SEARCH,
        ST_DIV,
        ST_WB
    } csl_state_t;

    // Temperature of one table point in output units.
    function automatic logic signed [TEMP_W-1:0] point_temp(
        input logic [TAB_IDX_W-1:0] idx
    );
        return TEMP_W'((BASE_DEG + STEP_DEG * int'(idx)) * (1 << FRAC_BITS));
    endfunction

endpackage

`default_nettype wire

// ===== design/csl_stream_if.sv =====
// ----------------------------------------------------------------------------
// csl_stream_if: valid/ready channel
// Carries one request per accepted handshake; the payload type is chosen at
// instantiation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/csl_div.sv =====
// ----------------------------------------------------------------------------
// csl_div: shared restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csl_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 10
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output csl_pkg::div_sts_t     sts,
    output logic      [NUM_W-1:0] quot
);
    import csl_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // One restoring step: shift in the next numerator bit and try to subtract.
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    // Step control and operand registers.
    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = num_reg;

endmodule

`default_nettype wire

// ===== design/calibrated_sensor_linearizer.sv =====
// ----------------------------------------------------------------------------
// calibrated_sensor_linearizer: gain calibration and table linearisation
// Scales a converter sample by a stored gain and interpolates a temperature
// from a fixed thermistor table; calibrate requests set the gain.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready until it has
// finished it. A calibrate request runs the shared divider, which takes 22
// steps to form 2^21 / sample; a zero sample skips the divider. A measure
// request does the gain multiply and the range check, and goes to writeback
// when the scaled value lies outside the table; otherwise it walks up to 11
// table points and runs the interpolation division in the same divider.
// Results are held in an output register, so the next request is accepted
// while a result still waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calibrated_sensor_linearizer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    csl_stream_if.sink   sample_in,
    csl_stream_if.source result_out
);
    import csl_pkg::*;

    csl_state_t                 state_reg, state_next;
    logic                       mode_reg, mode_next;
    logic [SAMPLE_W-1:0]        sample_reg, sample_next;
    logic [VAL_W-1:0]           val_reg, val_next;
    logic [TAB_IDX_W-1:0]       k_reg, k_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic signed [TEMP_W-1:0]   temp_reg, temp_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic                       out_valid_reg, out_valid_next;
    csl_out_t                   out_data_reg, out_data_next;

    logic                       in_fire;
    logic                       out_fire;
    logic                       out_free;
    logic                       walk_on;
    logic [PROD_W-1:0]          prod;
    logic [VAL_W-1:0]           lo_diff;
    logic [SAMPLE_W-1:0]        tab_lo;
    logic [SAMPLE_W-1:0]        tab_hi;

    logic                       div_start;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    div_sts_t                   div_sts;
    logic [DIV_NUM_W-1:0]       div_quot;

    // Handshakes.
    assign sample_in.ready    = (state_reg == ST_IDLE);
    assign in_fire            = sample_in.valid && sample_in.ready;
    assign out_fire           = out_valid_reg && result_out.ready;
    assign out_free           = !out_valid_reg || result_out.ready;
    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_data_reg;

    // Table neighbours of the current search point and the gain product.
    always_comb
    begin
        tab_hi  = LIN_TAB[k_reg];
        tab_lo  = LIN_TAB[k_reg - 1'b1];
        lo_diff = val_reg - {{(VAL_W - SAMPLE_W){1'b0}}, tab_lo};
        walk_on = (k_reg < TAB_IDX_W'(TABLE_POINTS - 1))
                  && (val_reg > {{(VAL_W - SAMPLE_W){1'b0}}, tab_hi});
        prod    = sample_reg * gain_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!sample_in.payload.mode)
                        state_next = ST_SCALE;
                    else if (sample_in.payload.adc_sample == '0)
                        state_next = ST_WB;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_SCALE:
                state_next = ST_RANGE;
            ST_RANGE:
            begin
                if (val_reg < {{(VAL_W - SAMPLE_W){1'b0}}, LIN_TAB[0]}
                    || val_reg > {{(VAL_W - SAMPLE_W){1'b0}}, LIN_TAB[TABLE_POINTS-1]})
                    state_next = ST_WB;
                else
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (!walk_on)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and divider control for each state.
    always_comb
    begin
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        val_next       = val_reg;
        k_next         = k_reg;
        gain_next      = gain_reg;
        temp_next      = temp_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_fire;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next   = sample_in.payload.mode;
                    sample_next = sample_in.payload.adc_sample;
                    temp_next   = '0;
                    status_next = STS_OK;
                    if (sample_in.payload.mode)
                    begin
                        if (sample_in.payload.adc_sample == '0)
                            status_next = STS_ZERO;
                        else
                        begin
                            div_start = 1'b1;
                            div_num   = CAL_NUMERATOR;
                            div_den   = sample_in.payload.adc_sample;
                        end
                    end
                end
            end
            ST_SCALE:
                val_next = prod[GAIN_SHIFT +: VAL_W];
            ST_RANGE:
            begin
                k_next = TAB_IDX_W'(1);
                priority if (val_reg < {{(VAL_W - SAMPLE_W){1'b0}}, LIN_TAB[0]})
                begin
                    status_next = STS_BELOW;
                    temp_next   = point_temp(TAB_IDX_W'(0));
                end
                else if (val_reg > {{(VAL_W - SAMPLE_W){1'b0}},
                                    LIN_TAB[TABLE_POINTS-1]})
                begin
                    status_next = STS_ABOVE;
                    temp_next   = point_temp(TAB_IDX_W'(TABLE_POINTS - 1));
                end
                else
                begin
                    status_next = STS_OK;
                end
            end
            ST_SEARCH:
            begin
                if (walk_on)
                    k_next = k_reg + 1'b1;
                else
                begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'(lo_diff) * DIV_NUM_W'(INTERP_SCALE);
                    div_den   = tab_hi - tab_lo;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    if (mode_reg)
                    begin
                        if (div_quot > {{(DIV_NUM_W - GAIN_W){1'b0}}, GAIN_MAX})
                            gain_next = GAIN_MAX;
                        else
                            gain_next = div_quot[GAIN_W-1:0];
                    end
                    else
                        temp_next = point_temp(k_reg - 1'b1) + TEMP_W'(div_quot);
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.temperature = temp_reg;
                    out_data_next.gain_factor = gain_reg;
                    out_data_next.status      = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= UNITY_GAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        sample_reg   <= sample_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        temp_reg     <= temp_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Shared divider for calibration and interpolation.
    csl_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .sts   (div_sts),
        .quot  (div_quot)
    );

`ifndef NO_ASSERTIONS
    // The gain only moves when a calibration division completes.
    a_gain_change: assert property (@(posedge clk) disable iff (!rst_n)
        (gain_reg != $past(gain_reg))
        |-> $past(state_reg == ST_DIV && div_sts.done && mode_reg))
        else $error("gain changed outside a calibration");

    // The divider reports completion only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // The table walk never leaves the interior segments.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH)
        |-> (k_reg >= TAB_IDX_W'(1) && k_reg <= TAB_IDX_W'(TABLE_POINTS - 1)))
        else $error("table index out of range");

    // A low clamp always reports the first table temperature.
    a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STS_BELOW)
        |-> (out_data_reg.temperature == point_temp(TAB_IDX_W'(0))))
        else $error("low clamp with wrong temperature");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_calibrated_sensor_linearizer.sv =====
// ----------------------------------------------------------------------------
// tb_calibrated_sensor_linearizer: self-checking bench for the linearizer
// Drives measure and calibrate requests through the valid/ready channels with
// random idling on both sides. A scoreboard class predicts every result from
// its own copy of the gain and the thermistor table, and checks each result
// field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calibrated_sensor_linearizer;

    import csl_pkg::*;

    localparam logic MODE_MEASURE   = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES  = 600;

    // Scoreboard: predicts the linearised reading of each accepted request and
    // compares the results against those predictions in order.
    class linearizer_scoreboard;
        logic [GAIN_W-1:0] gain_q412;
        csl_out_t          pending_readings[$];
        int unsigned       mismatches;
        int unsigned       measures;
        int unsigned       calibrations;
        int unsigned       clamped;
        int                thermistor_codes[13];

        function new();
            gain_q412        = 16'd4096;
            mismatches       = 0;
            measures         = 0;
            calibrations     = 0;
            clamped          = 0;
            thermistor_codes = '{75, 100, 131, 169, 214, 265, 322,
                                 384, 447, 512, 574, 633, 687};
        endfunction

        // Temperature in 1/32 degree of one table point.
        function int point_temp(int idx);
            return (-20 + 5 * idx) * 32;
        endfunction

        // Works out the reading for one request and updates the stored gain.
        function csl_out_t calibrated_reading(csl_in_t req);
            csl_out_t    res;
            int unsigned scaled;
            int unsigned quotient;
            int          k;
            int          lo;
            int          hi;
            int          temp;
            temp       = 0;
            res.status = STS_OK;
            if (req.mode == MODE_CALIBRATE)
            begin
                if (req.adc_sample == '0)
                begin
                    res.status = STS_ZERO;
                end
                else
                begin
                    quotient  = (32'd1 << 21) / int'(req.adc_sample);
                    gain_q412 = (quotient > 65535) ? 16'hFFFF : quotient[15:0];
                end
            end
            else
            begin
                scaled = (int'(req.adc_sample) * int'(gain_q412)) >> 12;
                if (scaled < thermistor_codes[0])
                begin
                    res.status = STS_BELOW;
                    temp       = point_temp(0);
                end
                else if (scaled > thermistor_codes[12])
                begin
                    res.status = STS_ABOVE;
                    temp       = point_temp(12);
                end
                else
                begin
                    // Walk to the first point at or above the scaled value.
                    k = 1;
                    while (k < 12 && scaled > thermistor_codes[k])
                        k++;
                    lo   = thermistor_codes[k - 1];
                    hi   = thermistor_codes[k];
                    temp = point_temp(k - 1) + (160 * (int'(scaled) - lo)) / (hi - lo);
                end
            end
            res.temperature = temp[TEMP_W-1:0];
            res.gain_factor = gain_q412;
            return res;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void note_request(csl_in_t req);
            csl_out_t res;
            res = calibrated_reading(req);
            if (req.mode == MODE_CALIBRATE)
                calibrations++;
            else
                measures++;
            if (res.status == STS_BELOW || res.status == STS_ABOVE)
                clamped++;
            pending_readings.push_back(res);
        endfunction

        task check_result(csl_out_t got);
            csl_out_t want;
            if (pending_readings.size() == 0)
            begin
                report($sformatf("result %p arrived with nothing pending", got));
                return;
            end
            want = pending_readings.pop_front();
            if (got.temperature !== want.temperature)
                report($sformatf("temperature %0d, expected %0d",
                                 got.temperature, want.temperature));
            if (got.gain_factor !== want.gain_factor)
                report($sformatf("gain_factor %0d, expected %0d",
                                 got.gain_factor, want.gain_factor));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;

    csl_stream_if #(.payload_t(csl_in_t))  sample_in ();
    csl_stream_if #(.payload_t(csl_out_t)) result_out ();

    calibrated_sensor_linearizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .result_out (result_out)
    );

    linearizer_scoreboard sb;
    bit          quiet_phase;
    int unsigned hold_off_cycles;
    int unsigned cycles;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Run-time guard.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_calibrated_sensor_linearizer: errors");
            $finish;
        end
    end

    // Offers one request, after a random gap unless idling is off.
    task automatic send_request(input logic mode, input int unsigned sample);
        csl_in_t     req;
        int unsigned gap;
        req.mode       = mode;
        req.adc_sample = sample[SAMPLE_W-1:0];
        gap = quiet_phase ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            sample_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in.valid   <= 1'b1;
        sample_in.payload <= req;
        do @(posedge clk); while (sample_in.ready !== 1'b1);
        sb.note_request(req);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_drained();
        sample_in.valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Mostly calibrations to sensible gains and samples that land in the
    // table under the current gain; the rest covers the full field range.
    function automatic csl_in_t random_request(logic [GAIN_W-1:0] gain);
        csl_in_t     req;
        int unsigned pick;
        int unsigned target;
        int unsigned s;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            req.mode = MODE_CALIBRATE;
            if (pick < 11)
                s = $urandom_range(256, 1023);
            else if (pick < 13)
                s = $urandom_range(0, 40);
            else
                s = $urandom_range(0, 1023);
        end
        else
        begin
            req.mode = MODE_MEASURE;
            if (pick < 80)
            begin
                target = $urandom_range(60, 700);
                s = (target * 4096) / int'(gain);
                if (s > 1023)
                    s = 1023;
            end
            else
            begin
                s = $urandom_range(0, 1023);
            end
        end
        req.adc_sample = s[SAMPLE_W-1:0];
        return req;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 16);
            if (hold_off_cycles != 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall != 0)
            begin
                result_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_out.ready <= 1'b1;
            do @(posedge clk); while (result_out.valid !== 1'b1);
            sb.check_result(result_out.payload);
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        csl_in_t req;
        sb                 = new();
        quiet_phase        = 1'b0;
        hold_off_cycles    = 0;
        rst_n             <= 1'b0;
        sample_in.valid   <= 1'b0;
        sample_in.payload <= '0;
        result_out.ready  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table edges at unity gain, then calibration corners.
        send_request(MODE_MEASURE, 0);
        send_request(MODE_MEASURE, 74);
        send_request(MODE_MEASURE, 75);
        send_request(MODE_MEASURE, 76);
        send_request(MODE_MEASURE, 100);
        send_request(MODE_MEASURE, 400);
        send_request(MODE_MEASURE, 512);
        send_request(MODE_MEASURE, 687);
        send_request(MODE_MEASURE, 688);
        send_request(MODE_MEASURE, 1023);
        send_request(MODE_CALIBRATE, 0);
        send_request(MODE_MEASURE, 300);
        send_request(MODE_CALIBRATE, 1);
        send_request(MODE_MEASURE, 1023);
        send_request(MODE_MEASURE, 4);
        send_request(MODE_MEASURE, 5);
        send_request(MODE_CALIBRATE, 31);
        send_request(MODE_CALIBRATE, 32);
        send_request(MODE_CALIBRATE, 33);
        send_request(MODE_CALIBRATE, 1023);
        send_request(MODE_MEASURE, 1023);
        send_request(MODE_MEASURE, 0);
        send_request(MODE_CALIBRATE, 512);
        send_request(MODE_MEASURE, 447);
        wait_drained();

        // Random requests with idling on both sides.
        repeat (300)
        begin
            req = random_request(sb.gain_q412);
            send_request(req.mode, req.adc_sample);
        end
        wait_drained();

        // Long output hold-off while requests keep coming back to back.
        hold_off_cycles = HOLD_CYCLES;
        quiet_phase     = 1'b1;
        repeat (12)
        begin
            req = random_request(sb.gain_q412);
            send_request(req.mode, req.adc_sample);
        end

        // A stretch with no idling at all.
        repeat (120)
        begin
            req = random_request(sb.gain_q412);
            send_request(req.mode, req.adc_sample);
        end
        wait_drained();
        quiet_phase = 1'b0;

        repeat (268)
        begin
            req = random_request(sb.gain_q412);
            send_request(req.mode, req.adc_sample);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d measure and %0d calibrate requests, %0d clamped readings,",
                 sb.measures, sb.calibrations, sb.clamped);
        $display("with random stalls, one long output hold-off and a gap-free stretch");
        if (sb.mismatches == 0)
        begin
            $display("tb_calibrated_sensor_linearizer: clean");
        end
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_calibrated_sensor_linearizer: errors");
        end
        $finish;
    end

endmodule
